>>> rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ADDR_W  = 12;
  localparam int ATTR_W  = 8;
  localparam int POS_W   = 11;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // attribute used when the bottom row is cleared
  localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h0F;

  // held line break codes
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_CR   = 2'd1;
  localparam logic [1:0] HOLD_LF   = 2'd2;

  // result operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SCROLL = 1'b1;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic              op_code;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [POS_W-1:0]  cursor_position;
    logic              run_end;
  } res_t;

endpackage

>>> rtl/core/tccw_chan_if.sv
`timescale 1ns / 1ps

interface tccw_in_if;
  logic                              valid;
  logic                              ready;
  logic [tccw_pkg::CHAR_W-1:0]       char_code;
  logic [tccw_pkg::COLOR_W-1:0]      fore_color;
  logic [tccw_pkg::COLOR_W-1:0]      back_color;
  logic                              end_of_string;

  modport source (output valid, char_code, fore_color, back_color, end_of_string,
                  input ready);
  modport sink (input valid, char_code, fore_color, back_color, end_of_string,
                output ready);
endinterface

interface tccw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         op_code;
  logic [tccw_pkg::ADDR_W-1:0]  cell_address;
  logic [tccw_pkg::CHAR_W-1:0]  cell_char;
  logic [tccw_pkg::ATTR_W-1:0]  cell_attr;
  logic [tccw_pkg::POS_W-1:0]   cursor_position;
  logic                         run_end;

  modport source (output valid, op_code, cell_address, cell_char, cell_attr,
                  cursor_position, run_end, input ready);
  modport sink (input valid, op_code, cell_address, cell_char, cell_attr,
                cursor_position, run_end, output ready);
endinterface

>>> rtl/core/tccw_step.sv
`timescale 1ns / 1ps

module tccw_step #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25,
  parameter int RW = $clog2(SCREEN_HEIGHT),
  parameter int CW = $clog2(SCREEN_WIDTH)
) (
  input  logic [RW-1:0]                      row,
  input  logic [CW-1:0]                      col,
  input  logic [1:0]                         pend,
  input  logic [tccw_pkg::CHAR_W-1:0]        char_code,
  input  logic [tccw_pkg::COLOR_W-1:0]       fore_color,
  input  logic [tccw_pkg::COLOR_W-1:0]       back_color,
  input  logic                               end_of_string,
  output logic [RW-1:0]                      row_nxt,
  output logic [CW-1:0]                      col_nxt,
  output logic [1:0]                         pend_nxt,
  output tccw_pkg::res_t [tccw_pkg::MAX_RES-1:0] res,
  output logic [1:0]                         res_cnt
);

  localparam logic [RW:0]   HEIGHT     = (RW+1)'(SCREEN_HEIGHT);
  localparam logic [RW-1:0] BOTTOM_ROW = RW'(SCREEN_HEIGHT - 1);
  localparam logic [CW:0]   WIDTH      = (CW+1)'(SCREEN_WIDTH);
  localparam int            SCROLL_ADDR = 2 * (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

  logic              is_cr, is_lf, is_brk, is_nul, partner, nl_a, scroll_a;
  logic              nl_b, hold, wr, wrap, adv_row, scroll_b;
  logic [RW:0]       row1, row2;
  logic [RW-1:0]     row1c;
  logic [CW-1:0]     col1;
  logic [CW:0]       colp;
  logic [tccw_pkg::ADDR_W-1:0] pos;
  tccw_pkg::res_t    scr_res, wr_res;

  always_comb begin
    is_cr  = (char_code == tccw_pkg::CH_CR);
    is_lf  = (char_code == tccw_pkg::CH_LF);
    is_brk = is_cr || is_lf;
    is_nul = (char_code == tccw_pkg::CH_NUL);

    // held break is dropped when its partner follows
    partner = ((pend == tccw_pkg::HOLD_CR) && is_lf) ||
              ((pend == tccw_pkg::HOLD_LF) && is_cr);
    nl_a = ((pend == tccw_pkg::HOLD_CR) || (pend == tccw_pkg::HOLD_LF)) && !partner;

    row1     = {1'b0, row} + (RW+1)'(nl_a);
    col1     = nl_a ? '0 : col;
    scroll_a = nl_a && (row1 >= HEIGHT);
    row1c    = scroll_a ? BOTTOM_ROW : row1[RW-1:0];

    nl_b = (is_brk && end_of_string) || is_nul;
    hold = is_brk && !end_of_string;
    wr   = !is_brk && !is_nul;

    pos  = tccw_pkg::ADDR_W'(row1c) * tccw_pkg::ADDR_W'(SCREEN_WIDTH) +
           tccw_pkg::ADDR_W'(col1);
    colp = {1'b0, col1} + (CW+1)'(1);
    wrap = colp >= WIDTH;

    adv_row  = nl_b || (wr && wrap);
    row2     = {1'b0, row1c} + (RW+1)'(adv_row);
    scroll_b = adv_row && (row2 >= HEIGHT);

    row_nxt  = scroll_b ? BOTTOM_ROW : row2[RW-1:0];
    if (nl_b || (wr && wrap)) begin
      col_nxt = '0;
    end else if (wr) begin
      col_nxt = colp[CW-1:0];
    end else begin
      col_nxt = col1;
    end
    pend_nxt = hold ? (is_cr ? tccw_pkg::HOLD_CR : tccw_pkg::HOLD_LF)
                    : tccw_pkg::HOLD_NONE;

    scr_res.op_code         = tccw_pkg::OP_SCROLL;
    scr_res.cell_address    = tccw_pkg::ADDR_W'(SCROLL_ADDR);
    scr_res.cell_char       = tccw_pkg::CH_SPACE;
    scr_res.cell_attr       = tccw_pkg::CLEAR_ATTR;
    scr_res.cursor_position = '0;
    scr_res.run_end         = 1'b0;

    wr_res.op_code         = tccw_pkg::OP_WRITE;
    wr_res.cell_address    = {pos[tccw_pkg::ADDR_W-2:0], 1'b0};
    wr_res.cell_char       = char_code;
    wr_res.cell_attr       = {back_color, fore_color};
    wr_res.cursor_position = pos[tccw_pkg::POS_W-1:0];
    wr_res.run_end         = 1'b0;

    // results in order: held-newline scroll, cell write, trailing scroll
    res[0] = (scroll_a || !wr) ? scr_res : wr_res;
    res[1] = (scroll_a && wr) ? wr_res : scr_res;
    res[2] = scr_res;
    res_cnt = 2'(scroll_a) + 2'(wr) + 2'(scroll_b);
    res[0].run_end = (res_cnt == 2'd1);
    res[1].run_end = (res_cnt == 2'd2);
    res[2].run_end = (res_cnt == 2'd3);
  end

endmodule

>>> rtl/core/text_console_cursor_writer_unit.sv
`timescale 1ns / 1ps

// Text console cursor writer. Each character item is turned, in the cycle it
// is accepted, into zero to three results (scroll, cell write, scroll) that go
// into a four-entry result queue; the queue drains one result per cycle while
// out_ch.ready is high. An item is taken whenever at most one result will be
// left in the queue after this cycle's take, so characters that give one
// result each flow at one item per cycle while the result port is not stalled.
// CR or LF without end_of_string is held until the next item and gives no
// result by itself. After reset the cursor sits at column 0 of row 5 (or of
// the bottom row on screens of five rows or fewer).
module text_console_cursor_writer_unit #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  tccw_in_if.sink    in_ch,
  tccw_out_if.source out_ch
);

  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int QD = 4;
  localparam logic [RW-1:0] RESET_ROW =
    (5 < SCREEN_HEIGHT) ? RW'(5) : RW'(SCREEN_HEIGHT - 1);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    pend_r, pend_nxt;
  tccw_pkg::res_t [tccw_pkg::MAX_RES-1:0] new_res;
  logic [1:0]    new_cnt;

  tccw_pkg::res_t q_r   [QD];
  tccw_pkg::res_t q_nxt [QD];
  logic [2:0]     cnt_r, cnt_nxt, base;
  logic           pop, push;

  tccw_step #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .RW            (RW),
    .CW            (CW)
  ) u_step (
    .row           (row_r),
    .col           (col_r),
    .pend          (pend_r),
    .char_code     (in_ch.char_code),
    .fore_color    (in_ch.fore_color),
    .back_color    (in_ch.back_color),
    .end_of_string (in_ch.end_of_string),
    .row_nxt       (row_nxt),
    .col_nxt       (col_nxt),
    .pend_nxt      (pend_nxt),
    .res           (new_res),
    .res_cnt       (new_cnt)
  );

  assign pop         = out_ch.valid && out_ch.ready;
  assign base        = cnt_r - 3'(pop);
  assign in_ch.ready = (base <= 3'd1);
  assign push        = in_ch.valid && in_ch.ready;
  assign cnt_nxt     = base + (push ? 3'(new_cnt) : 3'd0);

  // shift queue: survivors move down on a take, new results land behind them
  for (genvar i = 0; i < QD; i++) begin : g_q
    logic [2:0] slot;
    assign slot = 3'(i) - base;
    always_comb begin
      q_nxt[i] = q_r[i];
      if (3'(i) < base) begin
        if (i < QD - 1) begin
          q_nxt[i] = pop ? q_r[(i < QD - 1) ? i + 1 : i] : q_r[i];
        end
      end else if (push && (slot < 3'(new_cnt))) begin
        q_nxt[i] = new_res[slot[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= RESET_ROW;
      col_r  <= '0;
      pend_r <= tccw_pkg::HOLD_NONE;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        pend_r <= pend_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_ch.valid           = (cnt_r != 3'd0);
  assign out_ch.op_code         = q_r[0].op_code;
  assign out_ch.cell_address    = q_r[0].cell_address;
  assign out_ch.cell_char       = q_r[0].cell_char;
  assign out_ch.cell_attr       = q_r[0].cell_attr;
  assign out_ch.cursor_position = q_r[0].cursor_position;
  assign out_ch.run_end         = q_r[0].run_end;

endmodule

>>> tb/text_console_cursor_writer_unit_test.sv
`timescale 1ns / 1ps

module text_console_cursor_writer_unit_test;

  localparam int SCREEN_W    = 80;
  localparam int SCREEN_H    = 25;
  localparam int RAND_ITEMS  = 436;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [tccw_pkg::CHAR_W-1:0]  code;
    logic [tccw_pkg::COLOR_W-1:0] fg;
    logic [tccw_pkg::COLOR_W-1:0] bg;
    logic                         eos;
    bit                           drain_first;
  } char_item_t;

  logic clk;
  logic rst_n;

  tccw_in_if  in_ch();
  tccw_out_if out_ch();

  text_console_cursor_writer_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_item_t       char_q[$];
  tccw_pkg::res_t   cell_q[$];
  tccw_pkg::res_t   step_q[$];

  // cursor model
  int         cur_row;
  int         cur_col;
  logic [1:0] held_break;

  int  err_count;
  int  items_taken;
  int  writes_checked;
  int  scrolls_checked;
  int  cycle_count;
  int  send_gap;
  int  stall_left;
  bit  calm;
  bit  results_drained;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_cell(input logic op, input int addr,
                          input logic [tccw_pkg::CHAR_W-1:0] ch,
                          input logic [tccw_pkg::ATTR_W-1:0] attr, input int pos);
    tccw_pkg::res_t r;
    r.op_code         = op;
    r.cell_address    = addr[tccw_pkg::ADDR_W-1:0];
    r.cell_char       = ch;
    r.cell_attr       = attr;
    r.cursor_position = pos[tccw_pkg::POS_W-1:0];
    r.run_end         = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic wrap_bottom();
    if (cur_row >= SCREEN_H) begin
      cur_row = SCREEN_H - 1;
      add_cell(tccw_pkg::OP_SCROLL, 2 * (SCREEN_H - 1) * SCREEN_W, tccw_pkg::CH_SPACE,
               tccw_pkg::CLEAR_ATTR, 0);
    end
  endtask

  task automatic next_line();
    cur_col = 0;
    cur_row++;
    wrap_bottom();
  endtask

  task automatic predict_console(input char_item_t it);
    logic [1:0]     kind;
    int             pos;
    tccw_pkg::res_t last;
    kind = tccw_pkg::HOLD_NONE;
    step_q.delete();
    if (it.code == tccw_pkg::CH_CR) kind = tccw_pkg::HOLD_CR;
    else if (it.code == tccw_pkg::CH_LF) kind = tccw_pkg::HOLD_LF;
    // a held break is dropped only when its partner follows
    if ((held_break == tccw_pkg::HOLD_CR && kind != tccw_pkg::HOLD_LF) ||
        (held_break == tccw_pkg::HOLD_LF && kind != tccw_pkg::HOLD_CR)) next_line();
    held_break = tccw_pkg::HOLD_NONE;
    if (kind != tccw_pkg::HOLD_NONE) begin
      if (it.eos) next_line();
      else held_break = kind;
    end else if (it.code == tccw_pkg::CH_NUL) begin
      next_line();
    end else begin
      pos = cur_row * SCREEN_W + cur_col;
      add_cell(tccw_pkg::OP_WRITE, 2 * pos, it.code, {it.bg, it.fg}, pos);
      cur_col++;
      if (cur_col >= SCREEN_W) begin
        cur_col = 0;
        cur_row++;
      end
      wrap_bottom();
    end
    if (step_q.size() > 0) begin
      last = step_q.pop_back();
      last.run_end = 1'b1;
      step_q.push_back(last);
    end
    foreach (step_q[i]) cell_q.push_back(step_q[i]);
  endtask

  task automatic queue_char(input logic [tccw_pkg::CHAR_W-1:0] code,
                            input logic [tccw_pkg::COLOR_W-1:0] fg,
                            input logic [tccw_pkg::COLOR_W-1:0] bg, input logic eos,
                            input bit drain_first);
    char_item_t it;
    it.code        = code;
    it.fg          = fg;
    it.bg          = bg;
    it.eos         = eos;
    it.drain_first = drain_first;
    char_q.push_back(it);
  endtask

  // one string of random content, mostly well formed
  task automatic queue_string(inout int queued);
    int                           len;
    int                           r;
    bit                           noisy;
    bit                           last;
    logic [tccw_pkg::COLOR_W-1:0] fg;
    logic [tccw_pkg::COLOR_W-1:0] bg;
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(1, 24);
    else if (r < 95) len = $urandom_range(25, 90);
    else len = $urandom_range(90, 170);
    noisy = ($urandom_range(0, 9) == 0);
    fg = 4'($urandom_range(0, 15));
    bg = 4'($urandom_range(0, 15));
    for (int i = 0; i < len && queued < RAND_ITEMS; i++) begin
      last = (i == len - 1);
      if ($urandom_range(0, 7) == 0) begin
        fg = 4'($urandom_range(0, 15));
        bg = 4'($urandom_range(0, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 72) begin
        if ($urandom_range(0, 3) != 0)
          queue_char(8'($urandom_range(8'h20, 8'h7E)), fg, bg,
                     noisy ? 1'($urandom_range(0, 1)) : last, (queued % 115) == 57);
        else
          queue_char(8'($urandom_range(8'h01, 8'hFF)), fg, bg,
                     noisy ? 1'($urandom_range(0, 1)) : last, (queued % 115) == 57);
      end else if (r < 80) begin
        queue_char(tccw_pkg::CH_CR, fg, bg, 1'b0, 1'b0);
        queue_char(tccw_pkg::CH_LF, fg, bg, noisy ? 1'($urandom_range(0, 1)) : last, 1'b0);
        queued++;
      end else if (r < 84) begin
        queue_char(tccw_pkg::CH_LF, fg, bg, 1'b0, 1'b0);
        queue_char(tccw_pkg::CH_CR, fg, bg, noisy ? 1'($urandom_range(0, 1)) : last, 1'b0);
        queued++;
      end else if (r < 90) begin
        queue_char($urandom_range(0, 1) ? tccw_pkg::CH_CR : tccw_pkg::CH_LF, fg, bg,
                   noisy ? 1'($urandom_range(0, 1)) : last, 1'b0);
      end else if (r < 94) begin
        queue_char(tccw_pkg::CH_NUL, fg, bg, noisy ? 1'($urandom_range(0, 1)) : last, 1'b0);
      end else begin
        queue_char(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0);
      end
      queued++;
    end
  endtask

  // input side
  always @(posedge clk) begin
    char_item_t nxt;
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.char_code     <= '0;
      in_ch.fore_color    <= '0;
      in_ch.back_color    <= '0;
      in_ch.end_of_string <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (char_q.size() > 0 &&
                   !(char_q[0].drain_first && (in_ch.valid || !results_drained))) begin
        nxt = char_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.char_code     <= nxt.code;
        in_ch.fore_color    <= nxt.fg;
        in_ch.back_color    <= nxt.bg;
        in_ch.end_of_string <= nxt.eos;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // prediction on accepted items, checking on accepted results
  always @(posedge clk) begin
    char_item_t     it;
    tccw_pkg::res_t got;
    tccw_pkg::res_t want;
    if (!rst_n) begin
      cur_row    = (5 < SCREEN_H) ? 5 : SCREEN_H - 1;
      cur_col    = 0;
      held_break = tccw_pkg::HOLD_NONE;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.code        = in_ch.char_code;
        it.fg          = in_ch.fore_color;
        it.bg          = in_ch.back_color;
        it.eos         = in_ch.end_of_string;
        it.drain_first = 1'b0;
        predict_console(it);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.op_code         = out_ch.op_code;
        got.cell_address    = out_ch.cell_address;
        got.cell_char       = out_ch.cell_char;
        got.cell_attr       = out_ch.cell_attr;
        got.cursor_position = out_ch.cursor_position;
        got.run_end         = out_ch.run_end;
        if (cell_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result op=%0d addr=%0d char=%h attr=%h pos=%0d end=%0d",
                     $time, got.op_code, got.cell_address, got.cell_char, got.cell_attr,
                     got.cursor_position, got.run_end);
        end else begin
          want = cell_q.pop_front();
          if (got.op_code == tccw_pkg::OP_SCROLL) scrolls_checked++;
          else writes_checked++;
          if (got.op_code !== want.op_code || got.cell_address !== want.cell_address ||
              got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
              got.cursor_position !== want.cursor_position ||
              got.run_end !== want.run_end) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: mismatch after item %0d", $time, items_taken);
              $display("  expected op=%0d addr=%0d char=%h attr=%h pos=%0d end=%0d",
                       want.op_code, want.cell_address, want.cell_char, want.cell_attr,
                       want.cursor_position, want.run_end);
              $display("  actual   op=%0d addr=%0d char=%h attr=%h pos=%0d end=%0d",
                       got.op_code, got.cell_address, got.cell_char, got.cell_attr,
                       got.cursor_position, got.run_end);
            end
          end
        end
      end
    end
    results_drained <= (cell_q.size() == 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    calm <= ((cycle_count % 512) < 96);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, cell_q.size());
      $display("text_console_cursor_writer_unit test failed");
      $finish;
    end
  end

  initial begin
    int queued;
    rst_n <= 1'b0;

    // directed: field extremes and the line break cases
    queue_char(8'hFF, 4'hF, 4'hF, 1'b0, 1'b0);
    queue_char(8'h01, 4'h0, 4'h0, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_SPACE, 4'h7, 4'h1, 1'b1, 1'b0);
    queue_char(tccw_pkg::CH_NUL, 4'h3, 4'h3, 1'b0, 1'b0);
    // cr lf pair, then text
    queue_char(tccw_pkg::CH_CR, 4'h2, 4'h5, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_LF, 4'h2, 4'h5, 1'b0, 1'b0);
    queue_char("A", 4'h2, 4'h5, 1'b1, 1'b0);
    // lf cr pair
    queue_char(tccw_pkg::CH_LF, 4'hA, 4'h0, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_CR, 4'hA, 4'h0, 1'b0, 1'b0);
    queue_char("B", 4'hA, 4'h0, 1'b1, 1'b0);
    // held cr followed by a printable
    queue_char(tccw_pkg::CH_CR, 4'hC, 4'h8, 1'b0, 1'b0);
    queue_char("C", 4'hC, 4'h8, 1'b0, 1'b0);
    // break on the last character acts at once
    queue_char(tccw_pkg::CH_LF, 4'h1, 4'h2, 1'b1, 1'b0);
    // chain folds into one newline
    queue_char(tccw_pkg::CH_CR, 4'h4, 4'h4, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_LF, 4'h4, 4'h4, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_CR, 4'h4, 4'h4, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_LF, 4'h4, 4'h4, 1'b1, 1'b0);
    // two crs are not partners
    queue_char(tccw_pkg::CH_CR, 4'h9, 4'h6, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_CR, 4'h9, 4'h6, 1'b0, 1'b0);
    // string left with a held break across a full drain
    queue_char("D", 4'hE, 4'h3, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_CR, 4'hE, 4'h3, 1'b0, 1'b0);
    queue_char("E", 4'hE, 4'h3, 1'b1, 1'b1);
    // held lf then nul gives two newlines
    queue_char(tccw_pkg::CH_LF, 4'h5, 4'hB, 1'b0, 1'b0);
    queue_char(tccw_pkg::CH_NUL, 4'h5, 4'hB, 1'b1, 1'b0);

    queued = 0;
    while (queued < RAND_ITEMS) queue_string(queued);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_ch.valid || !results_drained) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (cell_q.size() > 0) begin
      err_count++;
      $display("%0d expected results never arrived", cell_q.size());
    end
    $display("%0d characters taken, %0d cell writes and %0d scrolls checked",
             items_taken, writes_checked, scrolls_checked);
    $display("covered line break folding, held breaks, wraps and bottom row scrolls");
    if (err_count == 0) begin
      $display("text_console_cursor_writer_unit test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("text_console_cursor_writer_unit test failed");
    end
    $finish;
  end

endmodule
